// File: hdl/lfg_pkg.sv
// Shared types and constants for the light effect generator.
package lfg_pkg;

    localparam int CNT_W = 16;
    localparam int BYTE_W = 8;
    localparam int NIB_W = 4;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [NIB_W-1:0]  t_nib;
    typedef logic [CNT_W-1:0]  t_cnt;

    // effect modes (low nibble of the setting byte)
    localparam t_nib MODE_HEADLIGHT = 4'd1;
    localparam t_nib MODE_ROOM1     = 4'd4;
    localparam t_nib MODE_ROOM2     = 4'd5;
    localparam t_nib MODE_ROOM3     = 4'd6;

    // flicker stage boundaries and dark-wait end
    localparam t_cnt FLK_STRIKE = 16'd40;
    localparam t_cnt FLK_DIM    = 16'd130;
    localparam t_cnt FLK_BRIGHT = 16'd180;
    localparam t_cnt FLK_MID    = 16'd210;
    localparam t_cnt FLK_END    = 16'd380;
    localparam t_cnt DARK_END   = 16'd400;

    localparam t_nib LOW_FILL = 4'hF;

    // one result beat
    typedef struct packed {
        t_byte brightness;
        logic  override_active;
        t_byte aux_value;
        logic  aux_written;
        logic  clear_count;
    } t_result;

endpackage

// File: hdl/lfg_ifs.sv
// Handshake channel interfaces: input beats, result beats, setting writes.
interface lfg_in_if import lfg_pkg::*; ();
    logic valid;
    logic ready;
    logic function_on;
    t_cnt effect_count;

    modport source (output valid, output function_on, output effect_count, input ready);
    modport sink   (input valid, input function_on, input effect_count, output ready);
endinterface

interface lfg_out_if import lfg_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte brightness;
    logic  override_active;
    t_byte aux_value;
    logic  aux_written;
    logic  clear_count;

    modport source (output valid, output brightness, output override_active,
                    output aux_value, output aux_written, output clear_count,
                    input ready);
    modport sink   (input valid, input brightness, input override_active,
                    input aux_value, input aux_written, input clear_count,
                    output ready);
endinterface

interface lfg_cfg_if import lfg_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte effect_setting;

    modport source (output valid, output effect_setting, input ready);
    modport sink   (input valid, input effect_setting, output ready);
endinterface

// File: hdl/light_effect_generator.sv
// Lamp effect generator: top level with input and result registers.
//
// Usage:
//   i_cfg  - setting byte writes: mode in bits 3..0, full level in 7..4.
//            Always ready; write only while no beat is in flight.
//   i_in   - one beat per timer tick: function_on and the external
//            effect_count.
//   o_out  - one result beat per input beat, in order: brightness,
//            override flag, aux value with its written flag, and a
//            request to clear the external counter.
// Timing:
//   Two-stage pipe: input register, then result register; a beat
//   shows on o_out once it moves into the result register. One beat
//   per cycle while o_out.ready is high; the only loop is the 8-bit
//   flicker ramp, updated as a running mode-4 beat leaves the input register.
// Stall:
//   Low o_out.ready holds the result beat; the input register still
//   fills, and i_in.ready drops only once both stages are full.
// Reset:
//   Synchronous, active low. Clears both stage valids, the setting
//   byte and the flicker ramp.
module light_effect_generator
    import lfg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfg_cfg_if.sink   i_cfg,
    lfg_in_if.sink    i_in,
    lfg_out_if.source o_out
);

    t_byte   r_setting;
    t_byte   r_step, n_step;
    logic    r_s1_valid;
    logic    r_on;
    t_cnt    r_cnt;
    logic    r_out_valid;
    t_result r_out, n_out;

    logic    s2_free, s1_move, in_take;
    t_nib    mode, lvl;
    t_byte   full, fade, step_inc, flk;

    assign i_cfg.ready = 1'b1;

    // result stage can take a beat when empty or draining
    assign s2_free   = !r_out_valid || o_out.ready;
    assign s1_move   = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || s1_move;
    assign in_take   = i_in.valid && i_in.ready;

    assign mode     = r_setting[NIB_W-1:0];
    assign lvl      = r_setting[BYTE_W-1:NIB_W];
    assign full     = {lvl, LOW_FILL};
    assign fade     = r_cnt[BYTE_W+1:2];
    assign step_inc = r_step + 8'd1;

    // flicker level, and ramp update, for a running mode-4 effect
    always_comb begin
        n_step = r_step;
        if (r_cnt < FLK_STRIKE) begin
            n_step = '0;
            flk    = {2'b00, lvl, 2'b11};
        end else if (r_cnt < FLK_DIM) begin
            flk = {4'b0000, lvl};
        end else if (r_cnt < FLK_BRIGHT) begin
            flk = {1'b0, lvl, 3'b111};
        end else if (r_cnt < FLK_MID) begin
            flk = {2'b00, lvl, 2'b11};
        end else if (r_cnt[3]) begin
            n_step = step_inc;
            flk    = {step_inc[BYTE_W-2:0], 1'b0};
        end else begin
            flk = {4'b0000, lvl};
        end
    end

    always_comb begin
        // idle: full level, no override or aux write; counter clear requested
        n_out = '{brightness: full, override_active: 1'b0, aux_value: '0,
                  aux_written: 1'b0, clear_count: 1'b1};
        if ((mode inside {MODE_HEADLIGHT, MODE_ROOM1, MODE_ROOM2, MODE_ROOM3}) && !r_on) begin
            n_out = '{brightness: '0, override_active: 1'b0, aux_value: '0,
                      aux_written: 1'b1, clear_count: 1'b1};
        end else if (mode inside {MODE_HEADLIGHT, MODE_ROOM3}) begin
            if (r_cnt == '0) begin
                n_out = '{brightness: full, override_active: 1'b0, aux_value: full,
                          aux_written: 1'b1, clear_count: 1'b1};
            end else if (fade[BYTE_W-1:NIB_W] >= lvl) begin
                // fade reached the level
                n_out = '{brightness: full, override_active: 1'b1,
                          aux_value: {fade[BYTE_W-1:NIB_W], LOW_FILL},
                          aux_written: 1'b1, clear_count: 1'b1};
            end else begin
                n_out = '{brightness: fade, override_active: 1'b1, aux_value: fade,
                          aux_written: 1'b1, clear_count: 1'b0};
            end
        end else if (mode == MODE_ROOM1 && r_cnt != '0) begin
            if (r_cnt >= FLK_END) begin
                n_out = '{brightness: full, override_active: 1'b0, aux_value: '0,
                          aux_written: 1'b1, clear_count: 1'b1};
            end else begin
                n_out = '{brightness: flk, override_active: 1'b1, aux_value: '0,
                          aux_written: 1'b1, clear_count: 1'b0};
            end
        end else if (mode == MODE_ROOM2 && r_cnt != '0) begin
            if (r_cnt >= DARK_END) begin
                n_out = '{brightness: full, override_active: 1'b0, aux_value: '0,
                          aux_written: 1'b1, clear_count: 1'b1};
            end else begin
                n_out = '{brightness: '0, override_active: 1'b0, aux_value: '0,
                          aux_written: 1'b1, clear_count: 1'b0};
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting   <= '0;
            r_step      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_setting <= i_cfg.effect_setting;
            end
            if (s1_move && mode == MODE_ROOM1 && r_on && r_cnt != '0 && r_cnt < FLK_END) begin
                r_step <= n_step;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_on  <= i_in.function_on;
            r_cnt <= i_in.effect_count;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.brightness      = r_out.brightness;
    assign o_out.override_active = r_out.override_active;
    assign o_out.aux_value       = r_out.aux_value;
    assign o_out.aux_written     = r_out.aux_written;
    assign o_out.clear_count     = r_out.clear_count;

endmodule

// File: hdl/lfg_checker.sv
// Port-level checks for the light effect generator, bound to the top level.
module lfg_checker
    import lfg_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_byte i_brightness,
    input logic  i_override_active,
    input t_byte i_aux_value,
    input logic  i_aux_written,
    input logic  i_clear_count
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    // aux is zero unless written
    a_aux_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_aux_written) |-> i_aux_value == '0)
        else $error("aux value set without write flag");

    // an override always writes aux
    a_ovr_aux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_override_active) |-> i_aux_written)
        else $error("override without aux write");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped under stall");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_brightness) && $stable(i_override_active) &&
             $stable(i_aux_value) && $stable(i_aux_written) && $stable(i_clear_count)))
        else $error("result beat changed under stall");

endmodule

bind light_effect_generator lfg_checker u_lfg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_brightness      (o_out.brightness),
    .i_override_active (o_out.override_active),
    .i_aux_value       (o_out.aux_value),
    .i_aux_written     (o_out.aux_written),
    .i_clear_count     (o_out.clear_count)
);
